// ----- rtl/core/ldg_pkg.sv -----
// Shared types and constants of the line direction grouper.
package ldg_pkg;

  localparam int unsigned NUM_GROUPS = 4;
  localparam int unsigned GOOD_BIT   = 4;
  localparam int unsigned SUM_W      = 20;

  localparam logic [15:0] GOOD_LIMIT_RST = 16'd10;

  localparam logic [1:0] KIND_GOOD  = 2'd0;
  localparam logic [1:0] KIND_OTHER = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  typedef struct packed {
    logic load;
    logic update;
    logic pick;
    logic scan_rst;
    logic scan1;
    logic scan2;
    logic mark;
  } ldg_cmd_t;

  typedef struct packed {
    logic last;
    logic scan_done;
  } ldg_stat_t;

endpackage

// ----- rtl/core/line_direction_grouper_unit.sv -----
// Top level of the line direction grouper: controller plus datapath.
// A line is accepted when start is high and busy is low. Each line holds busy
// in the CALC state after acceptance while its squared normal terms are compared
// and the group sums and line table are updated, so a new line is accepted only
// after that update. The line marked last additionally drives the output walk:
// PICK chooses the dominant group, then two serial passes over the line table
// run at one entry per cycle, each ending in a closing step, then the end marker
// is issued, so busy stays high until the end marker has gone out. Results
// appear in the cycle after the table entry is read, each for one cycle under
// out_valid; the receiver cannot stall, so every strobe must be taken.
// The config register may be written only while busy is low.
module line_direction_grouper_unit
  import ldg_pkg::*;
#(
  parameter int unsigned MAX_LINES = 16
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_dir_a,
  input  logic signed [15:0] in_dir_b,
  input  logic [15:0]        in_line_score,
  input  logic [15:0]        in_fit_deviation,
  input  logic [15:0]        in_fit_mean,
  input  logic               in_is_last,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  output logic               out_valid,
  output logic [1:0]         out_dominant_dir,
  output logic [1:0]         out_set_kind,
  output logic [3:0]         out_line_index,
  output logic               out_overflowed,
  output logic               out_run_end
);

  ldg_cmd_t  cmd;
  ldg_stat_t stat;

  ldg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ldg_datapath #(
    .MAX_LINES (MAX_LINES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_dir_a         (in_dir_a),
    .in_dir_b         (in_dir_b),
    .in_line_score    (in_line_score),
    .in_fit_deviation (in_fit_deviation),
    .in_fit_mean      (in_fit_mean),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_dominant_dir (out_dominant_dir),
    .out_set_kind     (out_set_kind),
    .out_line_index   (out_line_index),
    .out_overflowed   (out_overflowed),
    .out_run_end      (out_run_end)
  );

endmodule

// ----- rtl/core/ldg_ctrl.sv -----
// Control state machine of the line direction grouper.
module ldg_ctrl
  import ldg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ldg_stat_t stat,
  output ldg_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_SCAN1 = 3'd3;
  localparam logic [2:0] ST_SCAN2 = 3'd4;
  localparam logic [2:0] ST_MARK  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.update = 1'b1;
        state_nxt  = stat.last ? ST_PICK : ST_IDLE;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_SCAN1;
      end
      ST_SCAN1: begin
        if (stat.scan_done) begin
          cmd.scan_rst = 1'b1;
          state_nxt    = ST_SCAN2;
        end else begin
          cmd.scan1 = 1'b1;
        end
      end
      ST_SCAN2: begin
        if (stat.scan_done) begin
          state_nxt = ST_MARK;
        end else begin
          cmd.scan2 = 1'b1;
        end
      end
      ST_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_mark_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after the end marker");

  a_calc_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_CALC))
    else $error("accepted transaction was not processed");

  a_scan2_after_scan1: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rst |=> (state_r == ST_SCAN2))
    else $error("second pass did not follow the first");

endmodule

// ----- rtl/core/ldg_datapath.sv -----
// Datapath: direction tests, group accumulators, line table and result register.
module ldg_datapath
  import ldg_pkg::*;
#(
  parameter int unsigned MAX_LINES = 16
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  ldg_cmd_t           cmd,
  output ldg_stat_t          stat,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic signed [15:0] in_dir_a,
  input  logic signed [15:0] in_dir_b,
  input  logic [15:0]        in_line_score,
  input  logic [15:0]        in_fit_deviation,
  input  logic [15:0]        in_fit_mean,
  input  logic               in_is_last,
  output logic               out_valid,
  output logic [1:0]         out_dominant_dir,
  output logic [1:0]         out_set_kind,
  output logic [3:0]         out_line_index,
  output logic               out_overflowed,
  output logic               out_run_end
);

  localparam int unsigned LC_W  = $clog2(MAX_LINES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_LINES);
  localparam logic [LC_W-1:0] LC_MAX = LC_W'(MAX_LINES);

  logic [15:0] good_limit_r;

  // squares registered in the load cycle
  logic signed [16:0] sum_ab, dif_ba;
  logic signed [33:0] sq_aa, sq_bb, sq_ss, sq_dd;
  logic [32:0]        aa_r, bb_r, ss_r, dd_r;
  logic [15:0]        score_r;
  logic               good_r, last_r;

  logic [SUM_W-1:0]   sum_r   [NUM_GROUPS];
  logic [LC_W-1:0]    gcnt_r  [NUM_GROUPS];
  logic [GOOD_BIT:0]  member_r[MAX_LINES];
  logic [LC_W-1:0]    line_count_r;
  logic               overflow_r;

  logic [LC_W-1:0]    scan_idx_r;
  logic [1:0]         dom_r, first_r, second_r;

  logic               out_valid_r, out_run_end_r, out_overflowed_r;
  logic [1:0]         out_dir_r, out_kind_r;
  logic [3:0]         out_index_r;

  logic [34:0]        n2, t3aa, t3bb, t2ss, t2dd;
  logic [NUM_GROUPS-1:0] bits;
  logic [1:0]         dom_c, opp_c;
  logic [GOOD_BIT:0]  scan_m;
  logic [IDX_W+3:0]   scan_idx_x;
  logic               hit1, hit2;
  logic [SUM_W:0]     sum_add [NUM_GROUPS];

  assign sum_ab = 17'(in_dir_a) + 17'(in_dir_b);
  assign dif_ba = 17'(in_dir_b) - 17'(in_dir_a);
  assign sq_aa  = in_dir_a * in_dir_a;
  assign sq_bb  = in_dir_b * in_dir_b;
  assign sq_ss  = sum_ab * sum_ab;
  assign sq_dd  = dif_ba * dif_ba;

  assign n2   = 35'(aa_r) + 35'(bb_r);
  assign t3aa = 35'({aa_r, 1'b0}) + 35'(aa_r);
  assign t3bb = 35'({bb_r, 1'b0}) + 35'(bb_r);
  assign t2ss = 35'({ss_r, 1'b0});
  assign t2dd = 35'({dd_r, 1'b0});

  assign bits[0] = (t3aa < 35'(bb_r));
  assign bits[1] = (t2ss < n2);
  assign bits[2] = (t3bb < 35'(aa_r));
  assign bits[3] = (t2dd < n2);

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      sum_add[g] = {1'b0, sum_r[g]} + (SUM_W + 1)'(score_r);
    end
  end

  // highest score sum, lowest index on ties
  always_comb begin
    dom_c = 2'd0;
    for (int g = 1; g < NUM_GROUPS; g++) begin
      if (sum_r[dom_c] < sum_r[g]) dom_c = 2'(g);
    end
    opp_c = dom_c + 2'd2;
  end

  assign scan_m     = member_r[scan_idx_r[IDX_W-1:0]];
  assign scan_idx_x = {4'b0, scan_idx_r[IDX_W-1:0]};
  assign hit1       = scan_m[first_r] & scan_m[GOOD_BIT];
  assign hit2       = scan_m[second_r];

  assign stat.last      = last_r;
  assign stat.scan_done = (scan_idx_r == line_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_limit_r <= GOOD_LIMIT_RST;
    end else if (cfg_wr_en) begin
      good_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      aa_r    <= sq_aa[32:0];
      bb_r    <= sq_bb[32:0];
      ss_r    <= sq_ss[32:0];
      dd_r    <= sq_dd[32:0];
      score_r <= in_line_score;
      good_r  <= (in_fit_deviation < good_limit_r) && (in_fit_mean < good_limit_r);
      last_r  <= in_is_last;
    end
  end

  // member table holds no reset: only entries below the line count are read
  always_ff @(posedge clk) begin
    if (cmd.update && (line_count_r < LC_MAX)) begin
      member_r[line_count_r[IDX_W-1:0]] <= {good_r, bits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.mark) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        sum_r[g]  <= '0;
        gcnt_r[g] <= '0;
      end
      line_count_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.update) begin
      if (line_count_r < LC_MAX) begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          if (bits[g]) begin
            sum_r[g] <= sum_add[g][SUM_W] ? {SUM_W{1'b1}} : sum_add[g][SUM_W-1:0];
            if (good_r) gcnt_r[g] <= gcnt_r[g] + 1'b1;
          end
        end
        line_count_r <= line_count_r + 1'b1;
      end else begin
        overflow_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.pick || cmd.scan_rst) begin
      scan_idx_r <= '0;
    end else if (cmd.scan1 || cmd.scan2) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      dom_r <= dom_c;
      if (gcnt_r[dom_c] > gcnt_r[opp_c]) begin
        first_r  <= dom_c;
        second_r <= opp_c;
      end else begin
        first_r  <= opp_c;
        second_r <= dom_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.scan1 && hit1) || (cmd.scan2 && hit2) || cmd.mark;
    end
  end

  always_ff @(posedge clk) begin
    out_dir_r        <= dom_r;
    out_overflowed_r <= overflow_r;
    out_run_end_r    <= cmd.mark;
    if (cmd.mark) begin
      out_kind_r  <= KIND_MARK;
      out_index_r <= 4'd0;
    end else begin
      out_kind_r  <= cmd.scan2 ? KIND_OTHER : KIND_GOOD;
      out_index_r <= scan_idx_x[3:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dominant_dir = out_dir_r;
  assign out_set_kind     = out_kind_r;
  assign out_line_index   = out_index_r;
  assign out_overflowed   = out_overflowed_r;
  assign out_run_end      = out_run_end_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_count_r <= LC_MAX)
    else $error("line count exceeds capacity");

  a_mark_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |=> (line_count_r == '0) && !overflow_r)
    else $error("run state not cleared after end marker");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan1 || cmd.scan2) |-> (scan_idx_r < line_count_r))
    else $error("table scan past the line count");

endmodule

// ----- verif/line_direction_grouper_checker.sv -----
// Checker for the line direction grouper: predicts each run's results and compares them.
`timescale 1ns / 1ps
module line_direction_grouper_checker
  import ldg_pkg::*;
#(
  parameter int unsigned MAX_LINES = 16
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_dir_a,
  input  logic signed [15:0] in_dir_b,
  input  logic [15:0]        in_line_score,
  input  logic [15:0]        in_fit_deviation,
  input  logic [15:0]        in_fit_mean,
  input  logic               in_is_last,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               out_valid,
  input  logic [1:0]         out_dominant_dir,
  input  logic [1:0]         out_set_kind,
  input  logic [3:0]         out_line_index,
  input  logic               out_overflowed,
  input  logic               out_run_end,
  output int                 err_cnt,
  output int                 pending_cnt,
  output int                 result_cnt,
  output int                 dropped_runs
);

  localparam logic [SUM_W:0] SUM_SAT = {1'b0, {SUM_W{1'b1}}};

  typedef struct packed {
    logic [1:0] dir;
    logic [1:0] kind;
    logic [3:0] idx;
    logic       ovf;
    logic       run_end;
  } grp_result_t;

  // Per-run picture of the groups, as the block should hold it.
  logic [4:0]       line_bits [MAX_LINES];
  logic [SUM_W-1:0] score_sum [NUM_GROUPS];
  logic [4:0]       good_cnt  [NUM_GROUPS];
  int unsigned      stored;
  logic             dropped;
  logic [15:0]      good_limit;

  grp_result_t expected_q[$];
  grp_result_t want;
  grp_result_t got;
  int          errors  = 0;
  int          checked = 0;
  int          drops   = 0;

  task automatic clear_run();
    int i;
    for (i = 0; i < MAX_LINES; i++) line_bits[i] = '0;
    for (i = 0; i < NUM_GROUPS; i++) begin
      score_sum[i] = '0;
      good_cnt[i]  = '0;
    end
    stored  = 0;
    dropped = 1'b0;
  endtask

  // Near-perpendicular test against the four reference directions, exact in integers.
  function automatic logic [3:0] group_hits(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
    longint sa, sb, aa, bb, n2, s, d;
    sa = a;
    sb = b;
    aa = sa * sa;
    bb = sb * sb;
    n2 = aa + bb;
    s  = sa + sb;
    d  = sb - sa;
    return {(2 * d * d < n2), (3 * bb < aa), (2 * s * s < n2), (3 * aa < bb)};
  endfunction

  task automatic push_result(input int dom, input logic [1:0] kind, input int idx);
    grp_result_t r;
    r.dir     = 2'(dom);
    r.kind    = kind;
    r.idx     = 4'(idx);
    r.ovf     = dropped;
    r.run_end = (kind == KIND_MARK);
    expected_q = {expected_q, r};
  endtask

  task automatic absorb_line(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic [15:0] score, input logic [15:0] dev,
                             input logic [15:0] mean, input logic last);
    logic [3:0]   hits;
    logic         good;
    logic [SUM_W:0] total;
    int           g, i, dom, opp, first, second;
    if (stored < MAX_LINES) begin
      hits = group_hits(a, b);
      good = (dev < good_limit) && (mean < good_limit);
      for (g = 0; g < NUM_GROUPS; g++) begin
        if (hits[g]) begin
          total = score_sum[g] + score;
          score_sum[g] = (total > SUM_SAT) ? SUM_SAT[SUM_W-1:0] : total[SUM_W-1:0];
          if (good) good_cnt[g] = good_cnt[g] + 5'd1;
        end
      end
      line_bits[stored] = {good, hits};
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      dom = 0;
      for (g = 1; g < NUM_GROUPS; g++)
        if (score_sum[dom] < score_sum[g]) dom = g;
      opp = (dom + 2) % NUM_GROUPS;
      // opposite group leads on a tie in good counts
      if (good_cnt[dom] > good_cnt[opp]) begin
        first  = dom;
        second = opp;
      end else begin
        first  = opp;
        second = dom;
      end
      for (i = 0; i < stored; i++)
        if (line_bits[i][first] && line_bits[i][GOOD_BIT]) push_result(dom, KIND_GOOD, i);
      for (i = 0; i < stored; i++)
        if (line_bits[i][second]) push_result(dom, KIND_OTHER, i);
      push_result(dom, KIND_MARK, 0);
      if (dropped) drops++;
      clear_run();
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_run();
      good_limit = GOOD_LIMIT_RST;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        got.dir     = out_dominant_dir;
        got.kind    = out_set_kind;
        got.idx     = out_line_index;
        got.ovf     = out_overflowed;
        got.run_end = out_run_end;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: expected nothing, %s",
                   $time, $sformatf("actual dir=%0d kind=%0d index=%0d",
                                    got.dir, got.kind, got.idx));
        end else begin
          want = expected_q.pop_front();
          checked++;
          check_field("dominant_dir", want.dir, got.dir);
          check_field("set_kind", want.kind, got.kind);
          check_field("line_index", want.idx, got.idx);
          check_field("overflowed", want.ovf, got.ovf);
          check_field("run_end", want.run_end, got.run_end);
        end
      end
      // the register takes a write at the same edge, after the line has used the old value
      if (start && !busy)
        absorb_line(in_dir_a, in_dir_b, in_line_score, in_fit_deviation, in_fit_mean,
                    in_is_last);
      if (cfg_wr_en) good_limit = cfg_wr_data;
    end
    err_cnt      <= errors;
    pending_cnt  <= expected_q.size();
    result_cnt   <= checked;
    dropped_runs <= drops;
  end

endmodule

// ----- verif/line_direction_grouper_unit_test.sv -----
// Stimulus and verdict for the line direction grouper block test.
`timescale 1ns / 1ps
module line_direction_grouper_unit_test;
  import ldg_pkg::*;

  localparam int unsigned MAX_LINES      = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 2 * MAX_LINES + 8;
  localparam int unsigned SETTLE_CYCLES  = 4;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               start            = 1'b0;
  logic               busy;
  logic signed [15:0] in_dir_a         = '0;
  logic signed [15:0] in_dir_b         = '0;
  logic [15:0]        in_line_score    = '0;
  logic [15:0]        in_fit_deviation = '0;
  logic [15:0]        in_fit_mean      = '0;
  logic               in_is_last       = 1'b0;
  logic               cfg_wr_en        = 1'b0;
  logic [15:0]        cfg_wr_data      = '0;
  logic               out_valid;
  logic [1:0]         out_dominant_dir;
  logic [1:0]         out_set_kind;
  logic [3:0]         out_line_index;
  logic               out_overflowed;
  logic               out_run_end;

  int          err_cnt;
  int          pending_cnt;
  int          result_cnt;
  int          dropped_runs;
  int unsigned idle_pct     = 0;
  int unsigned lines_sent   = 0;
  int unsigned sets_sent    = 0;
  int unsigned cfg_writes   = 0;
  int unsigned quiet_cycles = 0;
  logic [15:0] cur_limit    = GOOD_LIMIT_RST;

  line_direction_grouper_unit #(.MAX_LINES(MAX_LINES)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_dir_a         (in_dir_a),
    .in_dir_b         (in_dir_b),
    .in_line_score    (in_line_score),
    .in_fit_deviation (in_fit_deviation),
    .in_fit_mean      (in_fit_mean),
    .in_is_last       (in_is_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_dominant_dir (out_dominant_dir),
    .out_set_kind     (out_set_kind),
    .out_line_index   (out_line_index),
    .out_overflowed   (out_overflowed),
    .out_run_end      (out_run_end)
  );

  line_direction_grouper_checker #(.MAX_LINES(MAX_LINES)) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_dir_a         (in_dir_a),
    .in_dir_b         (in_dir_b),
    .in_line_score    (in_line_score),
    .in_fit_deviation (in_fit_deviation),
    .in_fit_mean      (in_fit_mean),
    .in_is_last       (in_is_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_dominant_dir (out_dominant_dir),
    .out_set_kind     (out_set_kind),
    .out_line_index   (out_line_index),
    .out_overflowed   (out_overflowed),
    .out_run_end      (out_run_end),
    .err_cnt          (err_cnt),
    .pending_cnt      (pending_cnt),
    .result_cnt       (result_cnt),
    .dropped_runs     (dropped_runs)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // End the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_line(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic [15:0] score, input logic [15:0] dev,
                           input logic [15:0] mean, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_dir_a         <= a;
    in_dir_b         <= b;
    in_line_score    <= score;
    in_fit_deviation <= dev;
    in_fit_mean      <= mean;
    in_is_last       <= last;
    do @(posedge clk); while (busy);
    lines_sent++;
    if (last) sets_sent++;
  endtask

  // Hold off until every expected result is in and the block has gone quiet.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = value;
    cfg_writes++;
  endtask

  function automatic int extreme_value();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      3:       return 0;
      default: return 1;
    endcase
  endfunction

  task automatic rand_normal(output logic signed [15:0] a, output logic signed [15:0] b);
    int m, n, t;
    case ($urandom_range(5))
      0, 1: begin
        m = $urandom;
        n = $urandom;
      end
      2: begin
        m = int'($urandom_range(10)) - 5;
        n = int'($urandom_range(10)) - 5;
      end
      3: begin
        m = extreme_value();
        n = extreme_value();
      end
      4: begin
        // near the 60 degree edge of the axis groups
        m = $urandom_range(18000, 1000);
        n = m * 1732 / 1000 + int'($urandom_range(4)) - 2;
      end
      default: begin
        // near the edge of the diagonal groups
        m = $urandom_range(18000, 1000);
        n = -(m * 268 / 1000) + int'($urandom_range(4)) - 2;
      end
    endcase
    if ($urandom_range(1) == 1) begin
      t = m;
      m = n;
      n = t;
    end
    if ($urandom_range(1) == 1) m = -m;
    if ($urandom_range(1) == 1) n = -n;
    a = 16'(m);
    b = 16'(n);
  endtask

  function automatic logic [15:0] rand_score();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_fit();
    int k;
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: begin
        k = int'(cur_limit) + int'($urandom_range(2)) - 1;
        if (k < 0) k = 0;
        if (k > 65535) k = 65535;
        return 16'(k);
      end
      3, 4:    return 16'($urandom_range(40));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return GOOD_LIMIT_RST;
      3:       return 16'($urandom_range(64));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_set(input int count);
    logic signed [15:0] a, b;
    int i;
    for (i = 0; i < count; i++) begin
      rand_normal(a, b);
      send_line(a, b, rand_score(), rand_fit(), rand_fit(), i == count - 1);
    end
  endtask

  initial begin
    int          ph;
    int          len;
    int unsigned phase_end;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy);

    // lone zero normal: joins nothing, only the end marker comes out
    send_line(16'sd0, 16'sd0, 16'd1234, 16'd0, 16'd0, 1'b1);

    // extremes of every field, each group reached
    send_line(16'sd32767, 16'sd0, 16'hFFFF, 16'd0, 16'd0, 1'b0);
    send_line(16'sd0, -16'sd32768, 16'd0, 16'd9, 16'd9, 1'b0);
    send_line(-16'sd32768, -16'sd32768, 16'hFFFF, 16'd10, 16'd0, 1'b0);
    send_line(16'sd32767, -16'sd32768, 16'd1, 16'd0, 16'hFFFF, 1'b0);
    send_line(-16'sd1, 16'sd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_line(-16'sd32768, 16'sd32767, 16'd0, 16'd0, 16'd0, 1'b0);
    send_line(16'sd32767, 16'sd32767, 16'hFFFF, 16'd0, 16'd0, 1'b1);

    // score tie and good-count tie: lowest group wins, opposite group leads
    send_line(16'sd1, 16'sd0, 16'd500, 16'd0, 16'd0, 1'b0);
    send_line(16'sd0, 16'sd1, 16'd500, 16'd0, 16'd0, 1'b1);

    // dominant group with more good lines leads
    send_line(16'sd0, 16'sd5, 16'd100, 16'd0, 16'd0, 1'b0);
    send_line(16'sd0, 16'sd7, 16'd100, 16'd0, 16'd0, 1'b0);
    send_line(16'sd9, 16'sd1, 16'd150, 16'd50, 16'd0, 1'b1);

    // zero limit: no line can be good
    write_limit(16'h0000);
    send_line(16'sd3, 16'sd0, 16'd700, 16'd0, 16'd0, 1'b0);
    send_line(16'sd0, -16'sd3, 16'd200, 16'd0, 16'd0, 1'b1);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       idle_pct = 31;
        1:       idle_pct = 72;
        default: idle_pct = 0;
      endcase
      write_limit((ph == 0) ? 16'hFFFF : 16'($urandom_range(200)));
      phase_end = lines_sent + 100;
      while (lines_sent < phase_end) begin
        case ($urandom_range(9))
          0:       len = $urandom_range(MAX_LINES + 4, MAX_LINES + 1);
          1, 2:    len = $urandom_range(MAX_LINES, 9);
          default: len = $urandom_range(8, 1);
        endcase
        send_random_set(len);
        if ($urandom_range(3) == 0)
          write_limit(pick_limit());
        else if ($urandom_range(5) == 0)
          wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d lines in %0d sets over %0d limit settings; %0d results checked,",
             lines_sent, sets_sent, cfg_writes + 1, result_cnt);
    $display("%0d sets overflowed capacity, sender idling at 31, 72 and 0 percent.",
             dropped_runs);
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ldg_pkg.sv
rtl/core/ldg_ctrl.sv
rtl/core/ldg_datapath.sv
rtl/core/line_direction_grouper_unit.sv
verif/line_direction_grouper_checker.sv
verif/line_direction_grouper_unit_test.sv
